### src/opmc_pkg.sv
// Shared types, register codes and reset constants for the operator motor mode controller.
package opmc_pkg;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_LOW  = 2'd1,
        MODE_HIGH = 2'd2
    } fly_mode_t;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [2:0] REG_CONVEYOR_SLOW = 3'd0;
    localparam logic [2:0] REG_SLOW_SPEED    = 3'd1;
    localparam logic [2:0] REG_FULL_SPEED    = 3'd2;
    localparam logic [2:0] REG_SLEW_STEP     = 3'd3;
    localparam logic [2:0] REG_SETPOINT_STEP = 3'd4;

    localparam logic [6:0] SLOW_SPEED_RST    = 7'd25;
    localparam logic [6:0] FULL_SPEED_RST    = 7'd127;
    localparam logic [6:0] SLEW_STEP_RST     = 7'd1;
    localparam logic [6:0] SETPOINT_STEP_RST = 7'd5;

    localparam logic signed [7:0] HIGH_SETPOINT_RST = 8'sd80;
    localparam logic signed [7:0] LOW_SETPOINT_RST  = 8'sd62;
    localparam logic signed [7:0] DRIVE_LIM         = 8'sd127;

    // Button bit positions within the level vector.
    localparam int BTN_HIGH     = 0;
    localparam int BTN_LOW      = 1;
    localparam int BTN_RAISE    = 2;
    localparam int BTN_LOWER    = 3;
    localparam int BTN_CONVEYOR = 4;
    localparam int BTN_REVERSE  = 5;
    localparam int BTN_STYLE    = 6;

    typedef struct packed {
        logic signed [7:0] flywheel;
        logic signed [7:0] conveyor;
        logic signed [7:0] right;
        logic signed [7:0] left;
    } drive_t;

    // Clamp a 9-bit signed sum to -127..127.
    function automatic logic signed [7:0] sat9(input logic signed [8:0] v);
        logic signed [7:0] r;
        if (v > 9'sd127) begin
            r = DRIVE_LIM;
        end else if (v < -9'sd127) begin
            r = -DRIVE_LIM;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

### src/operator_motor_mode_controller_unit.sv
// Operator motor mode controller: input register, one pass of update logic, result register.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    seven button levels, three stick channels
//  m_       out        m_valid / m_ready    flywheel, conveyor, right and left drives
//  apb      in         psel/penable/pready  five control registers at 4*index
//
// One item per cycle sustained while m_ready is high; an accepted input passes from the input
// register through the combinational state update into the result register, which sets that rate.
// Reset (aresetn low, synchronous) empties both stages, clears the mode state and reloads the registers.
// A stalled result holds the input stage; s_ready drops only when both stages are full
// and m_ready is low.
module operator_motor_mode_controller_unit
    import opmc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_press_high,
    input  logic              s_press_low,
    input  logic              s_press_raise,
    input  logic              s_press_lower,
    input  logic              s_press_conveyor,
    input  logic              s_press_reverse,
    input  logic              s_press_style,
    input  logic signed [7:0] s_stick_turn,
    input  logic signed [7:0] s_stick_right,
    input  logic signed [7:0] s_stick_left,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [7:0] m_flywheel_drive,
    output logic signed [7:0] m_conveyor_drive,
    output logic signed [7:0] m_right_drive,
    output logic signed [7:0] m_left_drive,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // configuration registers
    logic       conveyor_slow_reg;
    logic [6:0] slow_speed_reg;
    logic [6:0] full_speed_reg;
    logic [6:0] slew_step_reg;
    logic [6:0] setpoint_step_reg;

    // input stage
    logic              in_valid_reg;
    logic [6:0]        levels_reg;
    logic signed [7:0] turn_reg;
    logic signed [7:0] fwd_reg;
    logic signed [7:0] lft_reg;

    // controller state
    logic [6:0]        prev_levels_reg, prev_levels_next;
    fly_mode_t         mode_reg, mode_next;
    logic signed [7:0] high_sp_reg, high_sp_next;
    logic signed [7:0] low_sp_reg, low_sp_next;
    logic signed [7:0] flywheel_level_reg, flywheel_level_next;
    logic              conv_run_reg, conv_run_next;
    logic              conv_rev_reg, conv_rev_next;
    logic              arcade_reg, arcade_next;

    // result stage
    logic   out_valid_reg;
    drive_t drive_reg, drive_next;

    logic       advance;
    logic       cfg_write;
    logic [2:0] cfg_index;
    logic [6:0] rise;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    assign m_flywheel_drive = drive_reg.flywheel;
    assign m_conveyor_drive = drive_reg.conveyor;
    assign m_right_drive    = drive_reg.right;
    assign m_left_drive     = drive_reg.left;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conveyor_slow_reg <= 1'b0;
            slow_speed_reg    <= SLOW_SPEED_RST;
            full_speed_reg    <= FULL_SPEED_RST;
            slew_step_reg     <= SLEW_STEP_RST;
            setpoint_step_reg <= SETPOINT_STEP_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_CONVEYOR_SLOW: conveyor_slow_reg <= pwdata[0];
                REG_SLOW_SPEED:    slow_speed_reg    <= pwdata[6:0];
                REG_FULL_SPEED:    full_speed_reg    <= pwdata[6:0];
                REG_SLEW_STEP:     slew_step_reg     <= pwdata[6:0];
                REG_SETPOINT_STEP: setpoint_step_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_CONVEYOR_SLOW: prdata = {31'd0, conveyor_slow_reg};
            REG_SLOW_SPEED:    prdata = {25'd0, slow_speed_reg};
            REG_FULL_SPEED:    prdata = {25'd0, full_speed_reg};
            REG_SLEW_STEP:     prdata = {25'd0, slew_step_reg};
            REG_SETPOINT_STEP: prdata = {25'd0, setpoint_step_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- update pass
    always_comb begin
        logic signed [7:0] sp;
        logic signed [8:0] sp_step;
        logic signed [8:0] target;
        logic signed [8:0] diff;
        logic signed [8:0] slew;
        logic signed [8:0] right_sum;
        logic signed [8:0] left_sum;
        logic signed [7:0] conv;

        rise             = levels_reg & ~prev_levels_reg;
        prev_levels_next = levels_reg;

        // high edge first, then low edge
        mode_next = mode_reg;
        if (rise[BTN_HIGH]) begin
            mode_next = (mode_next == MODE_HIGH) ? MODE_OFF : MODE_HIGH;
        end
        if (rise[BTN_LOW]) begin
            mode_next = (mode_next == MODE_LOW) ? MODE_OFF : MODE_LOW;
        end

        // nudge the active setpoint: raise then lower, saturating each time
        sp      = (mode_next == MODE_LOW) ? low_sp_reg : high_sp_reg;
        sp_step = {2'b00, setpoint_step_reg};
        if (rise[BTN_RAISE]) begin
            sp = sat9(9'(sp) + sp_step);
        end
        if (rise[BTN_LOWER]) begin
            sp = sat9(9'(sp) - sp_step);
        end
        high_sp_next = high_sp_reg;
        low_sp_next  = low_sp_reg;
        if (mode_next == MODE_LOW) begin
            low_sp_next = sp;
        end else if (mode_next == MODE_HIGH) begin
            high_sp_next = sp;
        end

        conv_run_next = conv_run_reg ^ rise[BTN_CONVEYOR];
        conv_rev_next = conv_rev_reg ^ rise[BTN_REVERSE];
        arcade_next   = arcade_reg ^ rise[BTN_STYLE];

        // slew toward the mode target, stopping exactly on it
        case (mode_next)
            MODE_LOW:  target = 9'(low_sp_next);
            MODE_HIGH: target = 9'(high_sp_next);
            default:   target = 9'sd0;
        endcase
        slew = {2'b00, slew_step_reg};
        diff = target - 9'(flywheel_level_reg);
        if (diff > slew) begin
            diff = slew;
        end else if (diff < -slew) begin
            diff = -slew;
        end
        flywheel_level_next = flywheel_level_reg + diff[7:0];

        if (arcade_next) begin
            right_sum = 9'(fwd_reg) - 9'(turn_reg);
            left_sum  = 9'(fwd_reg) + 9'(turn_reg);
        end else begin
            right_sum = 9'(fwd_reg);
            left_sum  = 9'(lft_reg);
        end

        conv = signed'({1'b0, conveyor_slow_reg ? slow_speed_reg : full_speed_reg});
        if (!conv_run_next) begin
            conv = 8'sd0;
        end else if (conv_rev_next) begin
            conv = -conv;
        end

        drive_next.flywheel = flywheel_level_next;
        drive_next.conveyor = conv;
        drive_next.right    = sat9(right_sum);
        drive_next.left     = sat9(left_sum);
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            prev_levels_reg    <= 7'd0;
            mode_reg           <= MODE_OFF;
            high_sp_reg        <= HIGH_SETPOINT_RST;
            low_sp_reg         <= LOW_SETPOINT_RST;
            flywheel_level_reg <= 8'sd0;
            conv_run_reg       <= 1'b0;
            conv_rev_reg       <= 1'b1;
            arcade_reg         <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg      <= 1'b1;
                prev_levels_reg    <= prev_levels_next;
                mode_reg           <= mode_next;
                high_sp_reg        <= high_sp_next;
                low_sp_reg         <= low_sp_next;
                flywheel_level_reg <= flywheel_level_next;
                conv_run_reg       <= conv_run_next;
                conv_rev_reg       <= conv_rev_next;
                arcade_reg         <= arcade_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            levels_reg <= {s_press_style, s_press_reverse, s_press_conveyor, s_press_lower,
                           s_press_raise, s_press_low, s_press_high};
            turn_reg   <= s_stick_turn;
            fwd_reg    <= s_stick_right;
            lft_reg    <= s_stick_left;
        end
        if (advance) begin
            drive_reg <= drive_next;
        end
    end

    // ---------------------------------------------------------------- assertions
    a_state_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(flywheel_level_reg) && $stable(mode_reg))
        else $error("controller state changed without a transfer into the result stage");

    a_conveyor_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !conv_run_reg |-> drive_reg.conveyor == 8'sd0)
        else $error("conveyor driven while off");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |-> !s_ready)
        else $error("input accepted while both stages are full and stalled");

    a_flywheel_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        flywheel_level_reg != -8'sd128)
        else $error("flywheel level left the -127..127 range");

endmodule
